// ===== rtl/telecommand_acceptance_checker_defines.svh =====
// Assertion macros used by the verification file of the telecommand
// acceptance checker.
`ifndef TELECOMMAND_ACCEPTANCE_CHECKER_DEFINES_SVH
`define TELECOMMAND_ACCEPTANCE_CHECKER_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define TCA_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, switched off while reset is high.
`define TCA_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define TCA_ASSERT_NXT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: reset check failed");

`endif

// ===== rtl/tca_pkg.sv =====
package tca_pkg;

  localparam int unsigned COUNT_W      = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] MIN_PACKET_LEN = 17'd13;
  localparam logic [COUNT_W-1:0] LENGTH_OFFSET  = 17'd7;
  localparam int unsigned PRI_BYTES    = 6;
  localparam int unsigned SEC_BYTES    = 5;
  localparam int unsigned APID_W       = 11;
  localparam int unsigned ACK_W        = 4;
  localparam int unsigned CFG_DATA_W   = 11;
  localparam int unsigned CFG_INDEX_W  = 1;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [3:0]  TC_PUS_REV   = 4'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_ACCEPTED_APID = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_SELECT    = 1'd1;

  typedef enum logic [2:0] {
    VERDICT_OK          = 3'd0,
    VERDICT_TRUNCATED   = 3'd1,
    VERDICT_BAD_LENGTH  = 3'd2,
    VERDICT_BAD_CRC     = 3'd3,
    VERDICT_BAD_VERSION = 3'd4,
    VERDICT_BAD_TYPE    = 3'd5,
    VERDICT_NO_SEC_HDR  = 3'd6,
    VERDICT_BAD_APID    = 3'd7
  } verdict_t;

  // One finished packet, handed from the parser to the verdict stage.
  typedef struct packed {
    logic [COUNT_W-1:0]     byte_count;
    logic [8*PRI_BYTES-1:0] primary_header;
    logic [8*SEC_BYTES-1:0] secondary_header;
    logic                   crc_ok;
  } tca_record_t;

  // Result word: the first field sits in the highest bits.
  typedef struct packed {
    logic        ack_requested;
    logic [15:0] app_data_length;
    logic [3:0]  ack_bits;
    logic [15:0] src_ident;
    logic [7:0]  svc_subtype;
    logic [7:0]  svc_type;
    logic [31:0] req_ident;
    verdict_t    verdict;
  } tca_result_t;

  localparam int unsigned RESULT_W = $bits(tca_result_t);

  typedef struct packed {
    logic full;
    logic empty;
  } tca_queue_status_t;

  // CRC-16-CCITT, MSB first, one byte.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// ===== rtl/telecommand_acceptance_checker.sv =====
// Telecommand acceptance checker.
// Input stream: one packet byte per request on s_axis_tdata, with s_axis_tlast
// high on the final byte of each packet. The block takes one byte every cycle
// while the record queue is not full; the parser updates the header capture,
// byte count and CRC-16-CCITT in the same cycle as it takes the byte.
// Output stream: one result per packet, 88 bits on m_axis_tdata, carrying the
// verdict and, for an accepted packet, the header fields it decoded.
// The packet record enters the queue at the edge that takes the final byte;
// the verdict stage pops it into the output register, raising m_axis_tvalid,
// once that register is empty or its result is being taken.
// Throughput: one byte per cycle for any mix of packet lengths while the queue
// is not full, set by the byte-wide CRC step in the parser.
// A two-entry queue sits between parser and verdict stage. If the receiver
// holds m_axis_tready low, the held result stays stable, the queue fills with
// up to two further packet records, and only then does s_axis_tready fall.
// Configuration: cfg_we with cfg_index 0 writes the accepted APID, index 1 the
// acknowledge mask; writes should be made while no packet is in flight.
// Reset (rst, synchronous, active high) clears the partial packet, empties the
// queue, drops m_axis_tvalid and sets both configuration registers to zero.
module telecommand_acceptance_checker
  import tca_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // [7:0] packet_byte
  input  logic                   s_axis_tlast,  // end_of_packet
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [2:0] verdict, [34:3] req_ident, [42:35] svc_type,
  // [50:43] svc_subtype, [66:51] src_ident, [70:67] ack_bits,
  // [86:71] app_data_length, [87] ack_requested
  output logic [RESULT_W-1:0]    m_axis_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [APID_W-1:0] accepted_apid;
  logic [ACK_W-1:0]  ack_select;

  tca_queue_status_t queue_status;
  tca_record_t       push_record;
  tca_record_t       head;
  tca_result_t       out_result;
  logic              push;
  logic              pop;

  // Configuration registers; values are trimmed to each register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_apid <= '0;
      ack_select    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACCEPTED_APID: accepted_apid <= cfg_data[APID_W-1:0];
        REG_ACK_SELECT:    ack_select    <= cfg_data[ACK_W-1:0];
        default:           ;
      endcase
    end
  end

  // Parser: captures headers, counts bytes and runs the CRC.
  tca_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .packet_byte   (s_axis_tdata),
    .end_of_packet (s_axis_tlast),
    .queue_status  (queue_status),
    .push          (push),
    .push_record   (push_record)
  );

  // Short queue of finished packet records.
  tca_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_record (push_record),
    .pop         (pop),
    .pop_record  (head),
    .status      (queue_status)
  );

  // Verdict stage with the output register.
  tca_back u_back (
    .clk           (clk),
    .rst           (rst),
    .queue_status  (queue_status),
    .head          (head),
    .pop           (pop),
    .accepted_apid (accepted_apid),
    .ack_select    (ack_select),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_result    (out_result)
  );

  assign m_axis_tdata = out_result;

endmodule

// ===== rtl/tca_front.sv =====
module tca_front
  import tca_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        packet_byte,
  input  logic              end_of_packet,
  input  tca_queue_status_t queue_status,
  output logic              push,
  output tca_record_t       push_record
);

  logic [COUNT_W-1:0]     byte_count;
  logic [8*PRI_BYTES-1:0] primary_header;
  logic [8*SEC_BYTES-1:0] secondary_header;
  logic [15:0]            crc_register;
  logic [15:0]            trailing_bytes;

  logic [COUNT_W-1:0]     byte_count_next;
  logic [8*PRI_BYTES-1:0] primary_header_next;
  logic [8*SEC_BYTES-1:0] secondary_header_next;
  logic [15:0]            crc_register_next;
  logic [15:0]            trailing_bytes_next;
  logic                   accept;

  assign in_ready = !queue_status.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && end_of_packet;

  always_comb begin
    primary_header_next   = primary_header;
    secondary_header_next = secondary_header;
    for (int i = 0; i < PRI_BYTES; i++) begin
      if (byte_count == COUNT_W'(i)) begin
        primary_header_next[8*(PRI_BYTES-1-i) +: 8] = packet_byte;
      end
    end
    for (int i = 0; i < SEC_BYTES; i++) begin
      if (byte_count == COUNT_W'(PRI_BYTES + i)) begin
        secondary_header_next[8*(SEC_BYTES-1-i) +: 8] = packet_byte;
      end
    end
    // The byte leaving the trailing window is the one that joins the CRC.
    if (byte_count >= COUNT_W'(2)) begin
      crc_register_next = crc_feed(crc_register, trailing_bytes[15:8]);
    end else begin
      crc_register_next = crc_register;
    end
    trailing_bytes_next = {trailing_bytes[7:0], packet_byte};
    byte_count_next = (byte_count != COUNT_MAX) ? byte_count + 1'b1 : byte_count;
  end

  assign push_record.byte_count       = byte_count_next;
  assign push_record.primary_header   = primary_header_next;
  assign push_record.secondary_header = secondary_header_next;
  assign push_record.crc_ok           = (crc_register_next == trailing_bytes_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      primary_header   <= '0;
      secondary_header <= '0;
      crc_register     <= CRC_INIT;
      trailing_bytes   <= '0;
    end else if (accept) begin
      if (end_of_packet) begin
        byte_count       <= '0;
        primary_header   <= '0;
        secondary_header <= '0;
        crc_register     <= CRC_INIT;
        trailing_bytes   <= '0;
      end else begin
        byte_count       <= byte_count_next;
        primary_header   <= primary_header_next;
        secondary_header <= secondary_header_next;
        crc_register     <= crc_register_next;
        trailing_bytes   <= trailing_bytes_next;
      end
    end
  end

endmodule

// ===== rtl/tca_queue.sv =====
module tca_queue
  import tca_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tca_record_t       push_record,
  input  logic              pop,
  output tca_record_t       pop_record,
  output tca_queue_status_t status
);

  tca_record_t entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;

  assign status.full  = (fill == 2'd2);
  assign status.empty = (fill == 2'd0);
  assign pop_record   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_record;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/tca_back.sv =====
module tca_back
  import tca_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  tca_queue_status_t queue_status,
  input  tca_record_t       head,
  output logic              pop,
  input  logic [APID_W-1:0] accepted_apid,
  input  logic [ACK_W-1:0]  ack_select,
  output logic              out_valid,
  input  logic              out_ready,
  output tca_result_t       out_result
);

  verdict_t           verdict;
  logic [COUNT_W-1:0] declared;
  logic [ACK_W-1:0]   ack;
  tca_result_t        result_next;

  assign pop = !queue_status.empty && (!out_valid || out_ready);

  always_comb begin
    declared = {1'b0, head.primary_header[15:0]} + LENGTH_OFFSET;
    ack      = head.secondary_header[35:32];
    if (head.byte_count < MIN_PACKET_LEN) begin
      verdict = VERDICT_TRUNCATED;
    end else if (declared != head.byte_count) begin
      verdict = VERDICT_BAD_LENGTH;
    end else if (!head.crc_ok) begin
      verdict = VERDICT_BAD_CRC;
    end else if (head.primary_header[47:45] != 3'd0) begin
      verdict = VERDICT_BAD_VERSION;
    end else if (!head.primary_header[44]) begin
      verdict = VERDICT_BAD_TYPE;
    end else if (!head.primary_header[43]) begin
      verdict = VERDICT_NO_SEC_HDR;
    end else if (head.primary_header[42:32] != accepted_apid) begin
      verdict = VERDICT_BAD_APID;
    end else if (head.secondary_header[39:36] != TC_PUS_REV) begin
      verdict = VERDICT_BAD_VERSION;
    end else begin
      verdict = VERDICT_OK;
    end

    result_next = '0;
    result_next.verdict = verdict;
    if (verdict == VERDICT_OK) begin
      result_next.req_ident       = head.primary_header[47:16];
      result_next.svc_type        = head.secondary_header[31:24];
      result_next.svc_subtype     = head.secondary_header[23:16];
      result_next.src_ident       = head.secondary_header[15:0];
      result_next.ack_bits        = ack;
      result_next.app_data_length = 16'(head.byte_count - MIN_PACKET_LEN);
      result_next.ack_requested   = |(ack & ack_select);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_result <= result_next;
    end
  end

endmodule

// ===== rtl/tca_checker.sv =====
`include "telecommand_acceptance_checker_defines.svh"

module tca_checker
  import tca_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [RESULT_W-1:0] m_axis_tdata
);

  logic failed;
  logic held;

  assign failed = m_axis_tvalid && (m_axis_tdata[2:0] != VERDICT_OK);
  assign held   = m_axis_tvalid && !m_axis_tready;

  // A rejected packet reports nothing but its verdict.
  `TCA_ASSERT_IMP(a_fail_fields_zero, clk, rst, failed, m_axis_tdata[RESULT_W-1:3] == '0)

  // The input only stalls once a result is being held back by the receiver.
  `TCA_ASSERT_IMP(a_stall_needs_backpressure, clk, rst, !s_axis_tready, m_axis_tvalid)

  // A held result does not change.
  `TCA_ASSERT_NXT(a_hold_stable, clk, rst, held, m_axis_tvalid && $stable(m_axis_tdata))

  // No result is shown straight after reset.
  `TCA_ASSERT_NXT_ALWAYS(a_reset_idle, clk, rst, !m_axis_tvalid && s_axis_tready)

endmodule

bind telecommand_acceptance_checker tca_checker u_tca_checker (.*);
